@@ rtl/rtd_pkg.sv @@
`timescale 1ns / 1ps

package rtd_pkg;

    // fixed point: intermediates carry 28 fraction bits
    localparam int FRAC_W = 28;

    // register-to-output latency of rtd_mul
    localparam int MUL_LAT = 3;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int COORD_W    = 32;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_K1 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_K2 = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K3 = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P1 = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P2 = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FX = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FY = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PP = 8'd7;

    // 1.0 in Q16.16, focal length after reset
    localparam logic [COORD_W-1:0] FOCAL_ONE = 32'h0001_0000;

    // 1.0 in Q.28
    localparam logic [FRAC_W:0] ONE_Q28 = {1'b1, {FRAC_W{1'b0}}};

    // output clamp limits
    localparam logic [COORD_W-1:0] PIX_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] PIX_MIN = 32'h8000_0000;

endpackage

@@ rtl/rtd_delay.sv @@
`timescale 1ns / 1ps

// plain shift line, no reset on payload
module rtd_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        r_line[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_line[i] <= r_line[i-1];
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

@@ rtl/rtd_mul.sv @@
`timescale 1ns / 1ps

// signed a*b scaled by 2^-28, round half away from zero.
// stage 1: two partial products (a split in halves)
// stage 2: partial products summed
// stage 3: rounded and truncated
module rtd_mul #(
    parameter int A_W = 32,
    parameter int B_W = 32,
    parameter int P_W = 36
) (
    input  logic                  i_clk,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    output logic signed [P_W-1:0] o_p
);

    localparam int LO_W  = A_W / 2;
    localparam int HI_W  = A_W - LO_W;
    localparam int PL_W  = LO_W + 1 + B_W;
    localparam int PH_W  = HI_W + B_W;
    localparam int SUM_W = A_W + B_W;
    localparam int RND_W = SUM_W + 1;
    localparam logic [RND_W-1:0] HALF = RND_W'(1) << (rtd_pkg::FRAC_W - 1);

    logic signed [PL_W-1:0]  r_pl, n_pl;
    logic signed [PH_W-1:0]  r_ph, n_ph;
    logic signed [SUM_W-1:0] r_prod, n_prod;
    logic        [P_W-1:0]   r_p, n_p;
    logic        [RND_W-1:0] rnd;

    always_comb begin
        n_pl   = $signed({1'b0, i_a[LO_W-1:0]}) * i_b;
        n_ph   = $signed(i_a[A_W-1:LO_W]) * i_b;
        n_prod = (SUM_W'(r_ph) <<< LO_W) + SUM_W'(r_pl);
        // negative values take one less, so the arithmetic shift rounds
        // ties away from zero
        rnd    = {r_prod[SUM_W-1], r_prod} + HALF - RND_W'(r_prod[SUM_W-1]);
        n_p    = rnd[rtd_pkg::FRAC_W +: P_W];
    end

    always_ff @(posedge i_clk) begin
        r_pl   <= n_pl;
        r_ph   <= n_ph;
        r_prod <= n_prod;
        r_p    <= n_p;
    end

    assign o_p = $signed(r_p);

endmodule

@@ rtl/radtan_distort_project.sv @@
`timescale 1ns / 1ps

// Channel    | Direction | Handshake                 | Payload
// -----------+-----------+---------------------------+--------------------------------
// point in   | in        | start & !busy             | i_norm_x, i_norm_y (Q3.28)
// config     | in        | i_cfg_valid & o_cfg_ready | i_cfg_index, i_cfg_data
// pixel out  | out       | o_done, one-cycle strobe  | o_pixel_u, o_pixel_v, o_overflow
//
// One point transaction may be started every cycle; busy is only raised in reset.
// The result strobe is reached through the dependency chain x^2 -> r2 -> r4
// -> r6 -> k3 r6 -> radial factor -> x c -> xd -> focal scale -> output
// clamp: six three-stage multipliers and four add stages (the last adds
// the principal point and clamps).
// Synchronous active-low reset clears the valid chain and loads the register
// reset values (focal lengths 1.0, all else 0). No stall anywhere: the
// receiver takes every strobe, so the pipeline free-runs.
// Config must be written only while the pipe is empty (a user rule that the
// block does not enforce); writes beyond index 7 are dropped.
module radtan_distort_project (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // point channel
    input  logic                             start,
    output logic                             busy,
    input  logic signed [rtd_pkg::COORD_W-1:0] i_norm_x,
    input  logic signed [rtd_pkg::COORD_W-1:0] i_norm_y,
    // config channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rtd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // result channel
    output logic                             o_done,
    output logic signed [rtd_pkg::COORD_W-1:0] o_pixel_u,
    output logic signed [rtd_pkg::COORD_W-1:0] o_pixel_v,
    output logic                             o_overflow
);

    localparam int CW = rtd_pkg::COORD_W;
    localparam int ML = rtd_pkg::MUL_LAT;

    // stage numbers, counted from the input register
    localparam int T_SQ  = ML;            // x^2, y^2, xy
    localparam int T_R2  = T_SQ + 1;      // r2, 2xy, r2+2x^2, r2+2y^2
    localparam int T_R4  = T_R2 + ML;
    localparam int T_R6  = T_R4 + ML;
    localparam int T_S   = T_R6 + 1;      // 1 + k1 r2 + k2 r4
    localparam int T_K3  = T_R6 + ML;
    localparam int T_C   = T_K3 + 1;      // radial factor
    localparam int T_TAN = T_R2 + ML + 1; // tangential sums
    localparam int T_XC  = T_C + ML;
    localparam int T_XD  = T_XC + 1;
    localparam int T_UP  = T_XD + ML;
    localparam int T_OUT = T_UP + 1;

    // value widths (magnitude bounds from 32-bit inputs and registers)
    localparam int SQ_W  = 36;  // x^2 <= 2^34
    localparam int R2_W  = 37;
    localparam int AX_W  = 38;
    localparam int R4_W  = 44;
    localparam int R6_W  = 51;
    localparam int K1_W  = 40;
    localparam int K2_W  = 47;
    localparam int K3_W  = 54;
    localparam int S_W   = 48;
    localparam int C_W   = 55;
    localparam int TP1_W = 40;  // p * 2xy
    localparam int TP2_W = 41;  // p * (r2 + 2x^2)
    localparam int TAN_W = 42;
    localparam int XC_W  = 58;
    localparam int XD_W  = 59;
    localparam int FS_W  = CW + 1;
    localparam int UP_W  = 63;
    localparam int SUM_W = 64;

    // ---------------- configuration registers ----------------
    logic signed [CW-1:0] r_k1, r_k2, r_k3, r_p1, r_p2;
    logic        [CW-1:0] r_fx, r_fy, r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= '0;
            r_k2 <= '0;
            r_k3 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
            r_fx <= rtd_pkg::FOCAL_ONE;
            r_fy <= rtd_pkg::FOCAL_ONE;
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rtd_pkg::REG_K1: r_k1 <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_K2: r_k2 <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_K3: r_k3 <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_P1: r_p1 <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_P2: r_p2 <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_FX: r_fx <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_FY: r_fy <= i_cfg_data[CW-1:0];
                rtd_pkg::REG_PP: begin
                    r_cx <= i_cfg_data[2*CW-1:CW];
                    r_cy <= i_cfg_data[CW-1:0];
                end
                default: ;
            endcase
        end
    end

    // handshakes only close in reset
    assign o_cfg_ready = i_rst_n;
    assign busy        = ~i_rst_n;

    // ---------------- valid chain ----------------
    logic [T_OUT:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[T_OUT-1:0], start};
        end
    end

    assign o_done = r_vld[T_OUT];

    // ---------------- stage 0: input register ----------------
    logic signed [CW-1:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        r_x <= i_norm_x;
        r_y <= i_norm_y;
    end

    // ---------------- squares ----------------
    logic signed [SQ_W-1:0] xx, yy, xy;

    rtd_mul #(.A_W(CW), .B_W(CW), .P_W(SQ_W)) u_mul_xx (
        .i_clk(i_clk), .i_a(r_x), .i_b(r_x), .o_p(xx));
    rtd_mul #(.A_W(CW), .B_W(CW), .P_W(SQ_W)) u_mul_yy (
        .i_clk(i_clk), .i_a(r_y), .i_b(r_y), .o_p(yy));
    rtd_mul #(.A_W(CW), .B_W(CW), .P_W(SQ_W)) u_mul_xy (
        .i_clk(i_clk), .i_a(r_x), .i_b(r_y), .o_p(xy));

    // ---------------- r2 and tangential operands ----------------
    logic signed [R2_W-1:0] r_r2, n_r2, r_xy2, n_xy2;
    logic signed [AX_W-1:0] r_ax, n_ax, r_ay, n_ay;

    always_comb begin
        n_r2  = R2_W'(xx) + R2_W'(yy);
        n_xy2 = R2_W'(xy) <<< 1;
        n_ax  = AX_W'(xx) + (AX_W'(xx) <<< 1) + AX_W'(yy);
        n_ay  = AX_W'(yy) + (AX_W'(yy) <<< 1) + AX_W'(xx);
    end

    always_ff @(posedge i_clk) begin
        r_r2  <= n_r2;
        r_xy2 <= n_xy2;
        r_ax  <= n_ax;
        r_ay  <= n_ay;
    end

    // ---------------- powers of r ----------------
    logic signed [R4_W-1:0] r4;
    logic signed [R2_W-1:0] r2_d;
    logic signed [R6_W-1:0] r6;

    rtd_mul #(.A_W(R2_W), .B_W(R2_W), .P_W(R4_W)) u_mul_r4 (
        .i_clk(i_clk), .i_a(r_r2), .i_b(r_r2), .o_p(r4));

    rtd_delay #(.WIDTH(R2_W), .DEPTH(T_R4 - T_R2)) u_dly_r2 (
        .i_clk(i_clk), .i_d(r_r2), .o_q(r2_d));

    rtd_mul #(.A_W(R4_W), .B_W(R2_W), .P_W(R6_W)) u_mul_r6 (
        .i_clk(i_clk), .i_a(r4), .i_b(r2_d), .o_p(r6));

    // ---------------- radial factor ----------------
    logic signed [K1_W-1:0] k1r2, k1r2_d;
    logic signed [K2_W-1:0] k2r4;
    logic signed [K3_W-1:0] k3r6;
    logic signed [S_W-1:0]  r_s, n_s, s_d;
    logic signed [C_W-1:0]  r_c, n_c;

    rtd_mul #(.A_W(R2_W), .B_W(CW), .P_W(K1_W)) u_mul_k1 (
        .i_clk(i_clk), .i_a(r_r2), .i_b(r_k1), .o_p(k1r2));

    rtd_delay #(.WIDTH(K1_W), .DEPTH(T_R6 - T_R4)) u_dly_k1 (
        .i_clk(i_clk), .i_d(k1r2), .o_q(k1r2_d));

    rtd_mul #(.A_W(R4_W), .B_W(CW), .P_W(K2_W)) u_mul_k2 (
        .i_clk(i_clk), .i_a(r4), .i_b(r_k2), .o_p(k2r4));

    rtd_mul #(.A_W(R6_W), .B_W(CW), .P_W(K3_W)) u_mul_k3 (
        .i_clk(i_clk), .i_a(r6), .i_b(r_k3), .o_p(k3r6));

    rtd_delay #(.WIDTH(S_W), .DEPTH(T_K3 - T_S)) u_dly_s (
        .i_clk(i_clk), .i_d(r_s), .o_q(s_d));

    always_comb begin
        n_s = S_W'($signed({1'b0, rtd_pkg::ONE_Q28})) + S_W'(k1r2_d) + S_W'(k2r4);
        n_c = C_W'(s_d) + C_W'(k3r6);
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_c <= n_c;
    end

    // ---------------- tangential terms ----------------
    logic signed [TP1_W-1:0] tp1x, tp2y;
    logic signed [TP2_W-1:0] tp2x, tp1y;
    logic signed [TAN_W-1:0] r_tx, n_tx, r_ty, n_ty, tx_d, ty_d;

    rtd_mul #(.A_W(R2_W), .B_W(CW), .P_W(TP1_W)) u_mul_p1x (
        .i_clk(i_clk), .i_a(r_xy2), .i_b(r_p1), .o_p(tp1x));
    rtd_mul #(.A_W(AX_W), .B_W(CW), .P_W(TP2_W)) u_mul_p2x (
        .i_clk(i_clk), .i_a(r_ax), .i_b(r_p2), .o_p(tp2x));
    rtd_mul #(.A_W(AX_W), .B_W(CW), .P_W(TP2_W)) u_mul_p1y (
        .i_clk(i_clk), .i_a(r_ay), .i_b(r_p1), .o_p(tp1y));
    rtd_mul #(.A_W(R2_W), .B_W(CW), .P_W(TP1_W)) u_mul_p2y (
        .i_clk(i_clk), .i_a(r_xy2), .i_b(r_p2), .o_p(tp2y));

    always_comb begin
        n_tx = TAN_W'(tp1x) + TAN_W'(tp2x);
        n_ty = TAN_W'(tp1y) + TAN_W'(tp2y);
    end

    always_ff @(posedge i_clk) begin
        r_tx <= n_tx;
        r_ty <= n_ty;
    end

    // held until the radial product lands
    rtd_delay #(.WIDTH(TAN_W), .DEPTH(T_XC - T_TAN)) u_dly_tx (
        .i_clk(i_clk), .i_d(r_tx), .o_q(tx_d));
    rtd_delay #(.WIDTH(TAN_W), .DEPTH(T_XC - T_TAN)) u_dly_ty (
        .i_clk(i_clk), .i_d(r_ty), .o_q(ty_d));

    // ---------------- distorted point ----------------
    logic signed [CW-1:0]   x_d, y_d;
    logic signed [XC_W-1:0] xc, yc;
    logic signed [XD_W-1:0] r_xd, n_xd, r_yd, n_yd;

    rtd_delay #(.WIDTH(CW), .DEPTH(T_C)) u_dly_x (
        .i_clk(i_clk), .i_d(r_x), .o_q(x_d));
    rtd_delay #(.WIDTH(CW), .DEPTH(T_C)) u_dly_y (
        .i_clk(i_clk), .i_d(r_y), .o_q(y_d));

    rtd_mul #(.A_W(C_W), .B_W(CW), .P_W(XC_W)) u_mul_xc (
        .i_clk(i_clk), .i_a(r_c), .i_b(x_d), .o_p(xc));
    rtd_mul #(.A_W(C_W), .B_W(CW), .P_W(XC_W)) u_mul_yc (
        .i_clk(i_clk), .i_a(r_c), .i_b(y_d), .o_p(yc));

    always_comb begin
        n_xd = XD_W'(xc) + XD_W'(tx_d);
        n_yd = XD_W'(yc) + XD_W'(ty_d);
    end

    always_ff @(posedge i_clk) begin
        r_xd <= n_xd;
        r_yd <= n_yd;
    end

    // ---------------- focal scale ----------------
    logic signed [FS_W-1:0] fx_s, fy_s;
    logic signed [UP_W-1:0] up, vp;

    assign fx_s = $signed({1'b0, r_fx});
    assign fy_s = $signed({1'b0, r_fy});

    rtd_mul #(.A_W(XD_W), .B_W(FS_W), .P_W(UP_W)) u_mul_fx (
        .i_clk(i_clk), .i_a(r_xd), .i_b(fx_s), .o_p(up));
    rtd_mul #(.A_W(XD_W), .B_W(FS_W), .P_W(UP_W)) u_mul_fy (
        .i_clk(i_clk), .i_a(r_yd), .i_b(fy_s), .o_p(vp));

    // ---------------- principal point and output clamp ----------------
    logic signed [SUM_W-1:0] sum_u, sum_v;
    logic                    ovf_u, ovf_v;
    logic [CW-1:0]           r_pix_u, n_pix_u, r_pix_v, n_pix_v;
    logic                    r_ovf, n_ovf;

    always_comb begin
        sum_u = SUM_W'(up) + $signed(SUM_W'(r_cx));
        sum_v = SUM_W'(vp) + $signed(SUM_W'(r_cy));
        // out of range when the top bits are not all copies of bit 31
        ovf_u = (sum_u[SUM_W-1:CW-1] != {(SUM_W-CW+1){sum_u[CW-1]}});
        ovf_v = (sum_v[SUM_W-1:CW-1] != {(SUM_W-CW+1){sum_v[CW-1]}});
        if (ovf_u) begin
            n_pix_u = sum_u[SUM_W-1] ? rtd_pkg::PIX_MIN : rtd_pkg::PIX_MAX;
        end else begin
            n_pix_u = sum_u[CW-1:0];
        end
        if (ovf_v) begin
            n_pix_v = sum_v[SUM_W-1] ? rtd_pkg::PIX_MIN : rtd_pkg::PIX_MAX;
        end else begin
            n_pix_v = sum_v[CW-1:0];
        end
        n_ovf = ovf_u | ovf_v;
    end

    always_ff @(posedge i_clk) begin
        r_pix_u <= n_pix_u;
        r_pix_v <= n_pix_v;
        r_ovf   <= n_ovf;
    end

    assign o_pixel_u  = $signed(r_pix_u);
    assign o_pixel_v  = $signed(r_pix_v);
    assign o_overflow = r_ovf;

endmodule

@@ bench/radtan_distort_project_tb.sv @@
`timescale 1ns / 1ps

module radtan_distort_project_tb;

    localparam int COORD_W = rtd_pkg::COORD_W;
    localparam int IDX_W   = rtd_pkg::CFG_IDX_W;
    localparam int DATA_W  = rtd_pkg::CFG_DATA_W;

    // pipeline depth from acceptance to result strobe; allow some slack on top
    localparam int PIPE_DEPTH  = 22;
    localparam int TAIL_CYCLES = PIPE_DEPTH + 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 112;
    localparam int RAND_PHASES = 10;
    localparam int GAP_PERCENT = 29;
    // first index past the register map; writes from here up are dropped
    localparam int REG_COUNT   = 8;

    localparam logic signed [63:0] UNITY     = 64'sd1 <<< rtd_pkg::FRAC_W;
    localparam logic signed [63:0] INNER_LIM = 64'sd1 <<< 60;
    localparam logic signed [63:0] PIX_HI    = 64'sd2147483647;
    localparam logic signed [63:0] PIX_LO    = -64'sd2147483648;

    typedef enum {LENS_TYPICAL, LENS_WILD, LENS_MAX, LENS_MIN} t_lens_kind;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
        logic               ovf;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_W-1:0]    i_norm_x = '0;
    logic [COORD_W-1:0]    i_norm_y = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_W-1:0]      i_cfg_index = '0;
    logic [DATA_W-1:0]     i_cfg_data = '0;
    logic                  o_done;
    logic [COORD_W-1:0]    o_pixel_u;
    logic [COORD_W-1:0]    o_pixel_v;
    logic                  o_overflow;

    // bench copy of the lens registers, reset values
    logic signed [63:0] lens_k1 = '0;
    logic signed [63:0] lens_k2 = '0;
    logic signed [63:0] lens_k3 = '0;
    logic signed [63:0] lens_p1 = '0;
    logic signed [63:0] lens_p2 = '0;
    logic [31:0]        focal_h = rtd_pkg::FOCAL_ONE;
    logic [31:0]        focal_v = rtd_pkg::FOCAL_ONE;
    logic [31:0]        centre_u = '0;
    logic [31:0]        centre_v = '0;

    t_point point_feed[$];      // points waiting to be offered
    t_pixel pending_pixels[$];  // predicted pixels, oldest first
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     gapless = 1'b0;

    radtan_distort_project dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_norm_x    (i_norm_x),
        .i_norm_y    (i_norm_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_pixel_u   (o_pixel_u),
        .o_pixel_v   (o_pixel_v),
        .o_overflow  (o_overflow)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // a*b scaled by 2^-28, rounded half away from zero, held to +-2^60.
    // Magnitudes stay below 2^64, so the 128-bit product is exact.
    function automatic logic signed [63:0] q28_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [127:0] mag_a;
        logic [127:0] mag_b;
        logic [127:0] scaled;
        logic [63:0]  mag;
        mag_a  = {64'd0, (a[63] ? -a : a)};
        mag_b  = {64'd0, (b[63] ? -b : b)};
        scaled = (mag_a * mag_b + (128'd1 << (rtd_pkg::FRAC_W - 1))) >> rtd_pkg::FRAC_W;
        mag    = (scaled > 128'(INNER_LIM)) ? INNER_LIM : scaled[63:0];
        return (a[63] ^ b[63]) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] sat60(input logic signed [63:0] val);
        if (val > INNER_LIM)
            return INNER_LIM;
        if (val < -INNER_LIM)
            return -INNER_LIM;
        return val;
    endfunction

    // final clamp to the signed 32-bit pixel range, flags a clip
    function automatic logic [31:0] clip_pixel(input logic signed [63:0] val,
                                               inout logic clipped);
        if (val > PIX_HI) begin
            clipped = 1'b1;
            return PIX_HI[31:0];
        end
        if (val < PIX_LO) begin
            clipped = 1'b1;
            return PIX_LO[31:0];
        end
        return val[31:0];
    endfunction

    function automatic t_pixel distort_point(input logic [31:0] nx, input logic [31:0] ny);
        logic signed [63:0] x, y, xx, yy, xy2, r2, r4, r6, ax, ay, c, xd, yd, u, v;
        logic               clipped;
        t_pixel             px;
        x   = {{32{nx[31]}}, nx};
        y   = {{32{ny[31]}}, ny};
        xx  = q28_mul(x, x);
        yy  = q28_mul(y, y);
        xy2 = sat60(q28_mul(x, y) <<< 1);
        r2  = sat60(xx + yy);
        r4  = q28_mul(r2, r2);
        r6  = q28_mul(r4, r2);
        ax  = sat60(r2 + (xx <<< 1));
        ay  = sat60(r2 + (yy <<< 1));
        // radial factor 1 + k1 r2 + k2 r4 + k3 r6
        c   = sat60(UNITY + q28_mul(lens_k1, r2) + q28_mul(lens_k2, r4)
                    + q28_mul(lens_k3, r6));
        xd  = sat60(q28_mul(x, c) + q28_mul(lens_p1, xy2) + q28_mul(lens_p2, ax));
        yd  = sat60(q28_mul(y, c) + q28_mul(lens_p1, ay) + q28_mul(lens_p2, xy2));
        // Q.28 times Q16.16 scaled by 2^-28 lands in Q16.16
        u   = q28_mul(xd, $signed({32'd0, focal_h})) + $signed({32'd0, centre_u});
        v   = q28_mul(yd, $signed({32'd0, focal_v})) + $signed({32'd0, centre_v});
        clipped = 1'b0;
        px.u    = clip_pixel(u, clipped);
        px.v    = clip_pixel(v, clipped);
        px.ovf  = clipped;
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Point driver: offers the feed queue, gaps at random unless gapless.
    // A prediction is queued at each accepting edge from the held payload.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : point_driver
        t_point nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                pending_pixels.push_back(distort_point(i_norm_x, i_norm_y));
            if (start && busy) begin
                // transaction still waiting, hold payload
            end else if (point_feed.size() > 0
                         && (gapless || $urandom_range(99) >= GAP_PERCENT)) begin
                nxt      = point_feed.pop_front();
                start    <= 1'b1;
                i_norm_x <= nxt.x;
                i_norm_y <= nxt.y;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobe must match the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : pixel_monitor
        t_pixel want;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected pixel u=%08h v=%08h ovf=%0b", $time,
                         o_pixel_u, o_pixel_v, o_overflow);
            end else begin
                want = pending_pixels.pop_front();
                if (want.u !== o_pixel_u) begin
                    mismatch_count++;
                    $display("%0t: pixel_u expected %08h got %08h", $time,
                             want.u, o_pixel_u);
                end
                if (want.v !== o_pixel_v) begin
                    mismatch_count++;
                    $display("%0t: pixel_v expected %08h got %08h", $time,
                             want.v, o_pixel_v);
                end
                if (want.ovf !== o_overflow) begin
                    mismatch_count++;
                    $display("%0t: overflow expected %0b got %0b", $time,
                             want.ovf, o_overflow);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d pixels outstanding", $time,
                     pending_pixels.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Register writes. Called at a clock edge; valid is left high so that
    // back-to-back writes never drop it within one step.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rtd_pkg::REG_K1: lens_k1 = {{32{data[31]}}, data[31:0]};
            rtd_pkg::REG_K2: lens_k2 = {{32{data[31]}}, data[31:0]};
            rtd_pkg::REG_K3: lens_k3 = {{32{data[31]}}, data[31:0]};
            rtd_pkg::REG_P1: lens_p1 = {{32{data[31]}}, data[31:0]};
            rtd_pkg::REG_P2: lens_p2 = {{32{data[31]}}, data[31:0]};
            rtd_pkg::REG_FX: focal_h = data[31:0];
            rtd_pkg::REG_FY: focal_v = data[31:0];
            rtd_pkg::REG_PP: begin
                centre_u = data[63:32];
                centre_v = data[31:0];
            end
            default: ;  // outside the map, dropped
        endcase
    endtask

    // signed Q.28 value drawn from [-half, +half]
    function automatic logic [31:0] small_q28(input int unsigned half);
        return 32'(int'($urandom_range(2 * half, 0)) - int'(half));
    endfunction

    // Writes all eight registers plus one junk index. Upper data bits of the
    // 32-bit registers carry noise that must be ignored.
    task automatic program_lens(input t_lens_kind kind);
        logic [31:0] k1, k2, k3, p1, p2, fx, fy;
        logic [63:0] pp;
        case (kind)
            LENS_TYPICAL: begin
                k1 = small_q28(32'h0800_0000);   // +-0.5
                k2 = small_q28(32'h0200_0000);
                k3 = small_q28(32'h0080_0000);
                p1 = small_q28(32'h0010_0000);
                p2 = small_q28(32'h0010_0000);
                fx = $urandom_range(2000, 100) << 16 | $urandom_range(16'hFFFF);
                fy = $urandom_range(2000, 100) << 16 | $urandom_range(16'hFFFF);
                pp = {32'($urandom_range(1920) << 16), 32'($urandom_range(1080) << 16)};
            end
            LENS_WILD: begin
                k1 = $urandom;
                k2 = $urandom;
                k3 = $urandom;
                p1 = $urandom;
                p2 = $urandom;
                fx = $urandom;
                fy = $urandom;
                pp = {$urandom, $urandom};
            end
            LENS_MAX: begin
                k1 = 32'h7FFF_FFFF;
                k2 = 32'h7FFF_FFFF;
                k3 = 32'h7FFF_FFFF;
                p1 = 32'h7FFF_FFFF;
                p2 = 32'h7FFF_FFFF;
                fx = 32'hFFFF_FFFF;
                fy = 32'hFFFF_FFFF;
                pp = '1;
            end
            default: begin
                k1 = 32'h8000_0000;
                k2 = 32'h8000_0000;
                k3 = 32'h8000_0000;
                p1 = 32'h8000_0000;
                p2 = 32'h8000_0000;
                fx = '0;
                fy = '0;
                pp = '0;
            end
        endcase
        write_reg(rtd_pkg::REG_K1, {$urandom, k1});
        write_reg(rtd_pkg::REG_K2, {$urandom, k2});
        write_reg(rtd_pkg::REG_K3, {$urandom, k3});
        write_reg(rtd_pkg::REG_P1, {$urandom, p1});
        write_reg(rtd_pkg::REG_P2, {$urandom, p2});
        write_reg(rtd_pkg::REG_FX, {$urandom, fx});
        write_reg(rtd_pkg::REG_FY, {$urandom, fy});
        write_reg(rtd_pkg::REG_PP, pp);
        write_reg(IDX_W'($urandom_range(255, REG_COUNT)), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until the pipe is empty and every pixel is back
    task automatic wait_drained();
        while (point_feed.size() != 0 || start || pending_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] edge_coord();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly points inside +-1.5 (a real image), some full range, some corners
    function automatic t_point random_point();
        t_point pt;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            pt.x = small_q28(32'h1800_0000);
            pt.y = small_q28(32'h1800_0000);
        end else if (pick < 90) begin
            pt.x = $urandom;
            pt.y = $urandom;
        end else begin
            pt.x = edge_coord();
            pt.y = edge_coord();
        end
        return pt;
    endfunction

    task automatic queue_directed();
        // corners of the Q3.28 range, unit points, one LSB below zero,
        // and products landing exactly on half an LSB (both signs)
        point_feed.push_back('{32'h0000_0000, 32'h0000_0000});
        point_feed.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF});
        point_feed.push_back('{32'h8000_0000, 32'h8000_0000});
        point_feed.push_back('{32'h7FFF_FFFF, 32'h8000_0000});
        point_feed.push_back('{32'h8000_0000, 32'h7FFF_FFFF});
        point_feed.push_back('{32'h1000_0000, 32'h0000_0000});
        point_feed.push_back('{32'h0000_0000, 32'h1000_0000});
        point_feed.push_back('{32'hF000_0000, 32'hF000_0000});
        point_feed.push_back('{32'h1000_0000, 32'hF000_0000});
        point_feed.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF});
        point_feed.push_back('{32'h0000_2000, 32'h0000_4000});
        point_feed.push_back('{32'hFFFF_E000, 32'h0000_4000});
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_lens_kind kind;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed set under reset registers (unit focal, no distortion)
        queue_directed();
        wait_drained();

        // same set with every coefficient and focal length at its maximum
        program_lens(LENS_MAX);
        queue_directed();
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            kind = t_lens_kind'(p % 4);
            // first phase keeps the maximum lens set; the rest reprogram
            if (p != 0)
                program_lens(kind);
            gapless = (p == 5);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // mid-phase hold-off until the pipe has fully emptied
                if (p == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                point_feed.push_back(random_point());
            end
            wait_drained();
        end
        gapless = 1'b0;

        // quiet tail: any stray strobe here is a failure
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d predicted pixels never arrived", $time,
                     pending_pixels.size());
        end
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rtd_pkg.sv
rtl/rtd_delay.sv
rtl/rtd_mul.sv
rtl/radtan_distort_project.sv
bench/radtan_distort_project_tb.sv
